@@ hdl/fors_pkg.sv @@
// Shared types, constants and helpers of the flash operation resource scheduler.
`timescale 1ns / 1ps
package fors_pkg;

  localparam int CHANNELS          = 4;
  localparam int LUN_COUNT         = 4;
  localparam int PLANE_COUNT       = 4;
  localparam int PLANE_PARALLELISM = 2;
  localparam int TICK_BITS         = 48;

  localparam int FIELD_W = 48;
  localparam int TW      = (TICK_BITS < FIELD_W) ? TICK_BITS : FIELD_W;
  localparam int DUR_W   = 34;
  localparam int CMP_W   = (TW > DUR_W) ? TW : DUR_W;

  localparam int CACHE_DEPTH = CHANNELS * LUN_COUNT * PLANE_COUNT;
  localparam int LANE_DEPTH  = CHANNELS * LUN_COUNT * PLANE_PARALLELISM;
  localparam int CACHE_IW    = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int LANE_IW     = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
  localparam int CH_IW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

  localparam logic [FIELD_W-1:0] TICK_MASK = FIELD_W'({TW{1'b1}});

  localparam logic [2:0] KIND_READ_TRIGGER = 3'd0;
  localparam logic [2:0] KIND_READ_XFER    = 3'd1;
  localparam logic [2:0] KIND_PROG_XFER    = 3'd2;
  localparam logic [2:0] KIND_PROG_EXEC    = 3'd3;
  localparam logic [2:0] KIND_ERASE        = 3'd4;
  localparam logic [2:0] KIND_STATUS       = 3'd5;

  localparam logic [2:0] CFG_READ_TRIGGER  = 3'd0;
  localparam logic [2:0] CFG_COMMAND       = 3'd1;
  localparam logic [2:0] CFG_XFER_PER_UNIT = 3'd2;
  localparam logic [2:0] CFG_PROG_FIXED    = 3'd3;
  localparam logic [2:0] CFG_PROG_PER_UNIT = 3'd4;
  localparam logic [2:0] CFG_ERASE         = 3'd5;
  localparam logic [2:0] CFG_STATUS        = 3'd6;
  localparam logic [2:0] CFG_TICK_LIMIT    = 3'd7;

  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         regions;
    logic [2:0]         channel;
    logic [2:0]         lun;
    logic [2:0]         plane;
    logic [FIELD_W-1:0] now_tick;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic [FIELD_W-1:0] start_at;
    logic [FIELD_W-1:0] finish_at;
    logic               res_kind;
  } rsp_t;

  // A classified request as it waits between the front and back ends.
  typedef struct packed {
    logic                ok;
    logic                xfer;
    logic [DUR_W-1:0]    dur;
    logic [TW-1:0]       now;
    logic [CH_IW-1:0]    ch_idx;
    logic [CACHE_IW-1:0] cache_idx;
    logic [LANE_IW-1:0]  lane_idx;
  } job_t;

  // Plane number modulo the plane parallelism, by repeated subtraction on a 3-bit value.
  function automatic logic [3:0] plane_lane(input logic [2:0] p);
    logic [3:0] r;
    r = {1'b0, p};
    for (int i = 0; i < 8; i++) begin
      if (r >= 4'(PLANE_PARALLELISM)) begin
        r = r - 4'(PLANE_PARALLELISM);
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/fors_front.sv @@
// Front end: timing registers, duration and address classification of each request.
`timescale 1ns / 1ps
module fors_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [fors_pkg::FIELD_W-1:0] cfg_data,
  input  fors_pkg::req_t            req,
  output fors_pkg::job_t            job,
  output logic [fors_pkg::TW-1:0]   limit
);
  import fors_pkg::*;

  logic [31:0]        read_trigger_ticks;
  logic [31:0]        cmd_ticks;
  logic [31:0]        xfer_unit_ticks;
  logic [31:0]        program_fixed_ticks;
  logic [31:0]        prog_unit_ticks;
  logic [31:0]        erase_ticks;
  logic [31:0]        stat_ticks;
  logic [FIELD_W-1:0] tick_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_trigger_ticks  <= '0;
      cmd_ticks           <= '0;
      xfer_unit_ticks     <= '0;
      program_fixed_ticks <= '0;
      prog_unit_ticks     <= '0;
      erase_ticks         <= '0;
      stat_ticks          <= '0;
      tick_limit          <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_READ_TRIGGER:  read_trigger_ticks  <= cfg_data[31:0];
        CFG_COMMAND:       cmd_ticks           <= cfg_data[31:0];
        CFG_XFER_PER_UNIT: xfer_unit_ticks     <= cfg_data[31:0];
        CFG_PROG_FIXED:    program_fixed_ticks <= cfg_data[31:0];
        CFG_PROG_PER_UNIT: prog_unit_ticks     <= cfg_data[31:0];
        CFG_ERASE:         erase_ticks         <= cfg_data[31:0];
        CFG_STATUS:        stat_ticks          <= cfg_data[31:0];
        CFG_TICK_LIMIT:    tick_limit          <= cfg_data;
      endcase
    end
  end

  assign limit = (tick_limit > TICK_MASK) ? TICK_MASK[TW-1:0] : tick_limit[TW-1:0];

  logic [1:0]       units;
  logic [32:0]      xfer_scaled;
  logic [32:0]      prog_scaled;
  logic [DUR_W-1:0] dur;
  logic             kind_ok;
  logic             xfer;
  logic             addr_ok;
  logic [3:0]       lane_in_group;
  int               lun_idx;

  assign units = {1'b0, req.regions[0]} + {1'b0, req.regions[1]};

  // Units is 0, 1 or 2, so the per-unit product is a select of a shift.
  always_comb begin
    case (units)
      2'd1:    xfer_scaled = {1'b0, xfer_unit_ticks};
      2'd2:    xfer_scaled = {xfer_unit_ticks, 1'b0};
      default: xfer_scaled = '0;
    endcase
    case (units)
      2'd1:    prog_scaled = {1'b0, prog_unit_ticks};
      2'd2:    prog_scaled = {prog_unit_ticks, 1'b0};
      default: prog_scaled = '0;
    endcase
  end

  always_comb begin
    kind_ok = 1'b1;
    xfer    = 1'b0;
    unique case (req.kind)
      KIND_READ_TRIGGER: dur = DUR_W'(read_trigger_ticks);
      KIND_READ_XFER, KIND_PROG_XFER: begin
        dur  = DUR_W'(cmd_ticks) + DUR_W'(xfer_scaled);
        xfer = 1'b1;
      end
      KIND_PROG_EXEC: dur = DUR_W'(program_fixed_ticks) + DUR_W'(prog_scaled);
      KIND_ERASE:     dur = DUR_W'(erase_ticks);
      KIND_STATUS: begin
        dur  = DUR_W'(stat_ticks);
        xfer = 1'b1;
      end
      default: begin
        dur     = '0;
        kind_ok = 1'b0;
      end
    endcase
  end

  assign addr_ok = ({1'b0, req.channel} < 4'(CHANNELS)) &&
                   ({1'b0, req.lun} < 4'(LUN_COUNT)) &&
                   ({1'b0, req.plane} < 4'(PLANE_COUNT));

  assign lane_in_group = plane_lane(req.plane);
  assign lun_idx = int'(req.channel) * LUN_COUNT + int'(req.lun);

  always_comb begin
    job.ok   = kind_ok && (dur != '0) && addr_ok;
    job.xfer = xfer;
    job.dur  = dur;
    job.now  = req.now_tick[TW-1:0];
    // Indexes stay at zero for a bad address so that no read leaves the stores.
    if (addr_ok) begin
      job.ch_idx    = CH_IW'(req.channel);
      job.cache_idx = CACHE_IW'(lun_idx * PLANE_COUNT + int'(req.plane));
      job.lane_idx  = LANE_IW'(lun_idx * PLANE_PARALLELISM + int'(lane_in_group));
    end else begin
      job.ch_idx    = '0;
      job.cache_idx = '0;
      job.lane_idx  = '0;
    end
  end

endmodule

@@ hdl/fors_queue.sv @@
// Two-entry queue of classified requests between the front and back ends.
`timescale 1ns / 1ps
module fors_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fors_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output fors_pkg::job_t head,
  output logic           empty
);
  import fors_pkg::*;

  job_t                slot [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr;
  logic [QUEUE_PW-1:0] rd_ptr;
  logic [QUEUE_PW:0]   count;

  assign full  = (count == (QUEUE_PW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/fors_back.sv @@
// Back end: busy-until stores, start and finish computation, result register.
`timescale 1ns / 1ps
module fors_back (
  input  logic                    clk,
  input  logic                    rst,
  input  fors_pkg::job_t          head,
  input  logic                    empty,
  output logic                    pop,
  input  logic [fors_pkg::TW-1:0] limit,
  output logic                    out_valid,
  input  logic                    out_ready,
  output fors_pkg::rsp_t          out_data
);
  import fors_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic state;

  logic [TW-1:0]          cache_mem [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] cache_vld;
  logic [TW-1:0]          chan_busy [CHANNELS];
  logic [TW-1:0]          lane_busy [LANE_DEPTH];

  job_t          cur;
  logic [TW-1:0] cache_rd;
  logic          cache_rd_vld;
  logic [TW-1:0] m1;
  logic [TW-1:0] room;
  logic          over;

  logic [TW-1:0] other;
  logic [TW-1:0] cache_cur;
  logic [TW-1:0] start;
  logic [TW-1:0] finish;
  logic          fits;
  logic          emit;

  assign pop   = (state == ST_IDLE) && !empty;
  assign other = head.xfer ? chan_busy[head.ch_idx] : lane_busy[head.lane_idx];

  assign cache_cur = cache_rd_vld ? cache_rd : '0;
  assign start     = (cache_cur > m1) ? cache_cur : m1;
  assign fits      = cur.ok && !over && (start <= room);
  // With the limit check passed, the duration is below 2^TW.
  assign finish    = start + TW'(cur.dur);
  assign emit      = (state == ST_CALC) && (!out_valid || out_ready);

  // First cycle: latch the job, read its cache entry and fold in the other resource.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur          <= head;
      cache_rd     <= cache_mem[head.cache_idx];
      m1           <= (other > head.now) ? other : head.now;
      over         <= CMP_W'(head.dur) > CMP_W'(limit);
      room         <= limit - TW'(head.dur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_rd_vld <= 1'b0;
    end else if (pop) begin
      cache_rd_vld <= cache_vld[head.cache_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (emit && fits) begin
      cache_mem[cur.cache_idx] <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_vld <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_busy[i] <= '0;
      end
      for (int i = 0; i < LANE_DEPTH; i++) begin
        lane_busy[i] <= '0;
      end
    end else if (emit && fits) begin
      cache_vld[cur.cache_idx] <= 1'b1;
      if (cur.xfer) begin
        chan_busy[cur.ch_idx] <= finish;
      end else begin
        lane_busy[cur.lane_idx] <= finish;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.accepted  <= fits;
      out_data.start_at  <= fits ? FIELD_W'(start) : '0;
      out_data.finish_at <= fits ? FIELD_W'(finish) : '0;
      out_data.res_kind  <= fits && !cur.xfer;
    end
  end

endmodule

@@ hdl/flash_op_resource_scheduler_top.sv @@
// Top level of the flash operation resource scheduler.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_data   (fors_pkg::req_t)
//   out      output     out_valid / out_ready out_data  (fors_pkg::rsp_t)
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// In the back end a request is popped in ST_IDLE, where its busy-until stores are read.
// In ST_CALC the start is picked, the limit checked, the finish written back and the
// result registered once no earlier result waits on out_ready; only then is another popped.
// Reset is synchronous; all busy-until ticks read as zero right after it.
// The two-entry queue keeps taking requests while a result waits on out_ready, until it is full.
`timescale 1ns / 1ps
module flash_op_resource_scheduler_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [2:0]                   cfg_index,
  input  logic [fors_pkg::FIELD_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fors_pkg::req_t               in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fors_pkg::rsp_t               out_data
);
  import fors_pkg::*;

  job_t          job;
  job_t          head;
  logic [TW-1:0] limit;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          q_push;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  fors_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (in_data),
    .job       (job),
    .limit     (limit)
  );

  fors_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (job),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty)
  );

  fors_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .limit     (limit),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/fors_checker.sv @@
// Port-level checks of the scheduler, bound to the top level.
`timescale 1ns / 1ps
module fors_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input fors_pkg::rsp_t out_data
);
  import fors_pkg::*;

  // A result beat that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A rejection carries all-zero fields.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.accepted |->
      out_data.start_at == '0 && out_data.finish_at == '0 &&
      !out_data.res_kind)
    else $error("rejected result has nonzero fields");

  // Every scheduled operation has a nonzero duration.
  a_finish_after_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted |-> out_data.finish_at > out_data.start_at)
    else $error("finish tick not after start tick");

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind flash_op_resource_scheduler_top fors_checker u_fors_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
